### hw/rtl/kst_pkg.sv
// shared constants and types for the minimum spanning tree block
package kst_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned MaxEdges    = 1024;
  localparam int unsigned EdgeIdxW    = $clog2(MaxEdges);
  localparam int unsigned EdgeCntW    = EdgeIdxW + 1;
  localparam int unsigned VcntW       = 7;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned TreeDepth   = MaxVertices - 1;
  localparam int unsigned KeyW        = 2 * VtxW;

  typedef struct packed {
    logic [VtxW-1:0]           lo;
    logic [VtxW-1:0]           hi;
    logic signed [WeightW-1:0] w;
  } edge_t;

endpackage

### hw/rtl/kruskal_spanning_tree.sv
// minimum spanning tree block: edge loading, selection sort, union-find and result output
//
// Edges load one per clock while busy is low (start high accepts one). The edge marked
// last_edge starts the run and busy stays high until the last result is registered.
// The run picks edges in (weight, arrival) order by scanning every stored edge once
// per picked edge, with a read and a compare state for each stored edge.
// Components are kept as labels in a 64-entry memory, set by an init sweep at the start
// of the run; each accepted edge starts a relabel sweep over the whole memory. The tree
// edges then go out in (low_end, high_end) order, one scan of the tree memory per result.
// Each result is on the ports for one cycle with result_valid_o high; the receiver
// cannot hold it off. With no edge in the tree a single empty result is given.
module kruskal_spanning_tree (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [kst_pkg::VtxW-1:0]     end_a_i,
  input  logic [kst_pkg::VtxW-1:0]     end_b_i,
  input  logic signed [kst_pkg::WeightW-1:0] weight_i,
  input  logic                         last_edge_i,
  output logic                         result_valid_o,
  output logic [kst_pkg::VtxW-1:0]     low_end_o,
  output logic [kst_pkg::VtxW-1:0]     high_end_o,
  output logic                         empty_res_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import kst_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_NEXT, S_SEL_RD, S_SEL_CMP, S_SEL_END, S_UF_RD, S_UF_CMP,
    S_SW_RD, S_SW_WR, S_OUT_INIT, S_OS_RD, S_OS_CMP, S_OS_EMIT
  } state_e;

  localparam logic [2:0] AddrVcount = 3'd0;

  state_e               state_q;
  logic [VcntW-1:0]     vcount_q;
  logic [EdgeCntW-1:0]  edge_total_q;
  logic [VtxW-1:0]      tree_total_q;
  logic [EdgeIdxW-1:0]  scan_q;
  logic [VtxW-1:0]      j_q;
  logic [VtxW-1:0]      k_q;
  logic [VtxW-1:0]      emitted_q;
  logic                 found_q;
  logic                 have_prev_q;
  edge_t                best_q;
  logic [EdgeIdxW-1:0]  best_idx_q;
  logic signed [WeightW-1:0] prev_w_q;
  logic [EdgeIdxW-1:0]  prev_idx_q;
  logic [KeyW-1:0]      best_key_q;
  logic [KeyW-1:0]      prev_key_q;
  logic [VtxW-1:0]      root_a_q, root_b_q;
  logic                 valid_q, empty_q, last_q;
  logic [VtxW-1:0]      low_q, high_q;

  // memories
  edge_t                edge_mem [MaxEdges];
  edge_t                edge_rd_q;
  logic [VtxW-1:0]      comp_mem [MaxVertices];
  logic [VtxW-1:0]      comp_a_q, comp_b_q;
  logic [KeyW-1:0]      tree_mem [TreeDepth];
  logic [KeyW-1:0]      tree_rd_q;

  logic [VcntW-1:0]     nv;
  logic                 load_ok, in_xfer, cfg_wr;
  edge_t                new_edge;
  logic                 edge_we;
  logic                 comp_we;
  logic [VtxW-1:0]      comp_waddr, comp_wdata, comp_raddr;
  logic                 tree_we;
  logic                 above_prev, below_best, key_ok;
  logic                 stop_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr == AddrVcount);
  assign prdata  = (paddr == AddrVcount) ? {{(32-VcntW){1'b0}}, vcount_q} : 32'd0;
  assign busy    = (state_q != S_LOAD);
  assign in_xfer = start && !busy;

  assign nv = (vcount_q > VcntW'(MaxVertices)) ? VcntW'(MaxVertices) : vcount_q;
  assign load_ok = ({1'b0, end_a_i} < nv) && ({1'b0, end_b_i} < nv)
                   && (edge_total_q < EdgeCntW'(MaxEdges));
  assign new_edge.lo = (end_a_i < end_b_i) ? end_a_i : end_b_i;
  assign new_edge.hi = (end_a_i < end_b_i) ? end_b_i : end_a_i;
  assign new_edge.w  = weight_i;
  assign edge_we     = in_xfer && load_ok;

  // candidate must come after the last pick in (weight, arrival) order
  assign above_prev = !have_prev_q || (edge_rd_q.w > prev_w_q)
                      || ((edge_rd_q.w == prev_w_q) && (scan_q > prev_idx_q));
  // ascending scan, so an equal weight never beats the current best
  assign below_best = !found_q || (edge_rd_q.w < best_q.w);
  assign key_ok     = (!have_prev_q || (tree_rd_q > prev_key_q))
                      && (!found_q || (tree_rd_q < best_key_q));
  assign stop_sel   = (nv <= VcntW'(1)) || (edge_total_q == '0)
                      || ({1'b0, tree_total_q} == nv - VcntW'(1));

  always_comb begin
    comp_we    = 1'b0;
    comp_waddr = j_q;
    comp_wdata = j_q;
    if (state_q == S_INIT) begin
      comp_we = 1'b1;
    end else if (state_q == S_SW_WR) begin
      comp_we    = (comp_a_q == root_b_q);
      comp_wdata = root_a_q;
    end
  end

  assign comp_raddr = (state_q == S_UF_RD) ? best_q.lo : j_q;
  assign tree_we    = (state_q == S_UF_CMP) && (comp_a_q != comp_b_q);

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_total_q[EdgeIdxW-1:0]] <= new_edge;
    end
    edge_rd_q <= edge_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (comp_we) begin
      comp_mem[comp_waddr] <= comp_wdata;
    end
    comp_a_q <= comp_mem[comp_raddr];
    comp_b_q <= comp_mem[best_q.hi];
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_total_q] <= {best_q.lo, best_q.hi};
    end
    tree_rd_q <= tree_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      vcount_q     <= VcntW'(MaxVertices);
      edge_total_q <= '0;
      tree_total_q <= '0;
      scan_q       <= '0;
      j_q          <= '0;
      k_q          <= '0;
      emitted_q    <= '0;
      found_q      <= 1'b0;
      have_prev_q  <= 1'b0;
      valid_q      <= 1'b0;
      empty_q      <= 1'b0;
      last_q       <= 1'b0;
      low_q        <= '0;
      high_q       <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_wr) begin
        vcount_q <= pwdata[VcntW-1:0];
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (load_ok) begin
              edge_total_q <= edge_total_q + EdgeCntW'(1);
            end
            if (last_edge_i) begin
              j_q     <= '0;
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          j_q <= j_q + VtxW'(1);
          if (j_q == VtxW'(MaxVertices - 1)) begin
            have_prev_q  <= 1'b0;
            found_q      <= 1'b0;
            tree_total_q <= '0;
            state_q      <= S_NEXT;
          end
        end
        S_NEXT: begin
          scan_q  <= '0;
          found_q <= 1'b0;
          state_q <= stop_sel ? S_OUT_INIT : S_SEL_RD;
        end
        S_SEL_RD: state_q <= S_SEL_CMP;
        S_SEL_CMP: begin
          if (above_prev && below_best) begin
            found_q    <= 1'b1;
            best_q     <= edge_rd_q;
            best_idx_q <= scan_q;
          end
          if ({1'b0, scan_q} == edge_total_q - EdgeCntW'(1)) begin
            state_q <= S_SEL_END;
          end else begin
            scan_q  <= scan_q + EdgeIdxW'(1);
            state_q <= S_SEL_RD;
          end
        end
        S_SEL_END: begin
          if (!found_q) begin
            state_q <= S_OUT_INIT;
          end else begin
            have_prev_q <= 1'b1;
            prev_w_q    <= best_q.w;
            prev_idx_q  <= best_idx_q;
            // edges beyond the vertex count in force are skipped
            if (({1'b0, best_q.lo} >= nv) || ({1'b0, best_q.hi} >= nv)) begin
              state_q <= S_NEXT;
            end else begin
              state_q <= S_UF_RD;
            end
          end
        end
        S_UF_RD: state_q <= S_UF_CMP;
        S_UF_CMP: begin
          if (comp_a_q == comp_b_q) begin
            state_q <= S_NEXT;
          end else begin
            root_a_q     <= comp_a_q;
            root_b_q     <= comp_b_q;
            tree_total_q <= tree_total_q + VtxW'(1);
            j_q          <= '0;
            state_q      <= S_SW_RD;
          end
        end
        S_SW_RD: state_q <= S_SW_WR;
        S_SW_WR: begin
          j_q <= j_q + VtxW'(1);
          state_q <= (j_q == VtxW'(MaxVertices - 1)) ? S_NEXT : S_SW_RD;
        end
        S_OUT_INIT: begin
          have_prev_q <= 1'b0;
          found_q     <= 1'b0;
          k_q         <= '0;
          emitted_q   <= '0;
          if (tree_total_q == '0) begin
            valid_q      <= 1'b1;
            empty_q      <= 1'b1;
            last_q       <= 1'b1;
            low_q        <= '0;
            high_q       <= '0;
            edge_total_q <= '0;
            state_q      <= S_LOAD;
          end else begin
            state_q <= S_OS_RD;
          end
        end
        S_OS_RD: state_q <= S_OS_CMP;
        S_OS_CMP: begin
          if (key_ok) begin
            found_q    <= 1'b1;
            best_key_q <= tree_rd_q;
          end
          if (k_q == tree_total_q - VtxW'(1)) begin
            state_q <= S_OS_EMIT;
          end else begin
            k_q     <= k_q + VtxW'(1);
            state_q <= S_OS_RD;
          end
        end
        S_OS_EMIT: begin
          valid_q     <= 1'b1;
          empty_q     <= 1'b0;
          low_q       <= best_key_q[KeyW-1:VtxW];
          high_q      <= best_key_q[VtxW-1:0];
          last_q      <= (emitted_q + VtxW'(1) == tree_total_q);
          prev_key_q  <= best_key_q;
          have_prev_q <= 1'b1;
          found_q     <= 1'b0;
          emitted_q   <= emitted_q + VtxW'(1);
          k_q         <= '0;
          if (emitted_q + VtxW'(1) == tree_total_q) begin
            edge_total_q <= '0;
            tree_total_q <= '0;
            state_q      <= S_LOAD;
          end else begin
            state_q <= S_OS_RD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign low_end_o      = low_q;
  assign high_end_o     = high_q;
  assign empty_res_o    = empty_q;
  assign last_o         = last_q;

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && empty_res_o |-> last_o && (low_end_o == '0) && (high_end_o == '0))
    else $error("empty result malformed");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("block idle before the final result");

  a_load_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_edge_i |=> !busy)
    else $error("busy without a final edge");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (tree_total_q == '0))
    else $error("tree count not cleared while loading");

endmodule
